>>> hw/rtl/lrr_pkg.sv
// Shared types and constants for the line rasterizer with rotation.
package lrr_pkg;

  // Default coordinate width of the logical endpoints
  localparam int COORD_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int PANEL_W     = 13;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROTATION     = 2'd0,
    CFG_PANEL_WIDTH  = 2'd1,
    CFG_PANEL_HEIGHT = 2'd2
  } cfg_index_t;

  // Display rotation codes
  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_mode_t;

  // Request kinds carried in tuser
  typedef enum logic {
    REQ_START = 1'b0,
    REQ_TICK  = 1'b1
  } req_type_t;

  // Register reset values
  localparam logic [PANEL_W-1:0] PANEL_WIDTH_RST  = 13'd128;
  localparam logic [PANEL_W-1:0] PANEL_HEIGHT_RST = 13'd64;

  // Color width
  localparam int COLOR_W = 32;

endpackage

>>> hw/rtl/line_rasterizer_with_rotation.sv
// Bresenham line rasterizer with display rotation: top level.
// The pixel of an accepted start or tick item is written into the queue, then
// rotated into the output register that drives m_tvalid.
// One item is taken per cycle while the queue has room (s_tready); a tick
// with no active line gives no pixel. A two-entry queue and the output register
// absorb stalls. Synchronous active-high reset idles the line, empties the
// queue and output, and sets rotation 0 and a 128 by 64 panel.
module line_rasterizer_with_rotation #(
  parameter int COORD_BITS = lrr_pkg::COORD_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_wr_en,
  input  logic [lrr_pkg::CFG_INDEX_W-1:0]             cfg_index,
  input  logic [lrr_pkg::CFG_DATA_W-1:0]              cfg_wr_data,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // start_x, start_y, end_x, end_y, pixel_color (low bit up)
  input  logic [((4*COORD_BITS+32+7)/8)*8-1:0]        s_tdata,
  // req_type
  input  logic                                        s_tuser,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // pixel_x, pixel_y, out_color (low bit up)
  output logic [((2*(COORD_BITS+1)+32+7)/8)*8-1:0]    m_tdata,
  // last_pixel
  output logic                                        m_tlast
);

  localparam int QW = 2*COORD_BITS + lrr_pkg::COLOR_W + 1;

  logic          push, push_ready, pop, pop_valid;
  logic [QW-1:0] push_data, pop_data;

  lrr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  lrr_queue #(.WIDTH(QW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid)
  );

  lrr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .pop_valid   (pop_valid),
    .pop_data    (pop_data),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule

>>> hw/rtl/lrr_front.sv
// Front end: takes start and tick items and runs the Bresenham stepper.
module lrr_front #(
  parameter int COORD_BITS = lrr_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // start_x, start_y, end_x, end_y, pixel_color (low bit up)
  input  logic [((4*COORD_BITS+32+7)/8)*8-1:0]      s_tdata,
  // req_type
  input  logic                                      s_tuser,
  output logic                                      push,
  // x, y, color, last (low bit up)
  output logic [2*COORD_BITS+lrr_pkg::COLOR_W:0]    push_data,
  input  logic                                      push_ready
);

  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;
  localparam int EW  = CW + 3;
  localparam int E2W = CW + 4;

  // Line state
  logic signed [CW-1:0]  cursor_x, cursor_y, target_x, target_y;
  logic [DW-1:0]         delta_x_abs;
  logic signed [DW-1:0]  delta_y_neg;
  logic                  step_x_neg, step_y_neg;
  logic signed [EW-1:0]  error_term;
  logic [lrr_pkg::COLOR_W-1:0] line_color;
  logic                  line_active;

  // Unpacked item fields
  logic signed [CW-1:0]  in_sx, in_sy, in_ex, in_ey;
  logic [lrr_pkg::COLOR_W-1:0] in_color;
  logic                  is_start, accept;

  // Start setup
  logic signed [DW-1:0]  dx_s, dy_s;
  logic [DW-1:0]         dxa_s;
  logic signed [DW-1:0]  dyn_s;
  logic signed [EW-1:0]  err_s;

  // Tick step
  logic signed [E2W-1:0] e2;
  logic                  x_go, y_go;
  logic signed [EW-1:0]  dyn_e, dxa_e, err_next;
  logic signed [CW-1:0]  nx, ny, x_inc, y_inc;

  // Result
  logic signed [CW-1:0]  res_x, res_y, res_tx, res_ty;
  logic [lrr_pkg::COLOR_W-1:0] res_color;
  logic                  done;

  assign in_sx    = s_tdata[0*CW +: CW];
  assign in_sy    = s_tdata[1*CW +: CW];
  assign in_ex    = s_tdata[2*CW +: CW];
  assign in_ey    = s_tdata[3*CW +: CW];
  assign in_color = s_tdata[4*CW +: lrr_pkg::COLOR_W];
  assign is_start = (lrr_pkg::req_type_t'(s_tuser) == lrr_pkg::REQ_START);

  assign s_tready = push_ready;
  assign accept   = s_tvalid && s_tready;

  // Set up deltas and error for a new line
  always_comb begin
    dx_s  = DW'(in_ex) - DW'(in_sx);
    dy_s  = DW'(in_ey) - DW'(in_sy);
    dxa_s = dx_s[DW-1] ? DW'(-dx_s) : DW'(dx_s);
    dyn_s = dy_s[DW-1] ? dy_s : -dy_s;
    err_s = $signed(EW'(dxa_s)) + EW'(dyn_s);
  end

  // Advance one pixel along the active line
  always_comb begin
    e2       = {error_term, 1'b0};
    dyn_e    = EW'(delta_y_neg);
    dxa_e    = $signed(EW'(delta_x_abs));
    x_go     = (e2 >= E2W'(delta_y_neg));
    y_go     = (e2 <= $signed(E2W'(delta_x_abs)));
    x_inc    = step_x_neg ? {CW{1'b1}} : CW'(1);
    y_inc    = step_y_neg ? {CW{1'b1}} : CW'(1);
    nx       = x_go ? cursor_x + x_inc : cursor_x;
    ny       = y_go ? cursor_y + y_inc : cursor_y;
    err_next = error_term;
    if (x_go) begin
      err_next = err_next + dyn_e;
    end
    if (y_go) begin
      err_next = err_next + dxa_e;
    end
  end

  // Pick the emitted pixel
  always_comb begin
    res_x     = is_start ? in_sx : nx;
    res_y     = is_start ? in_sy : ny;
    res_tx    = is_start ? in_ex : target_x;
    res_ty    = is_start ? in_ey : target_y;
    res_color = is_start ? in_color : line_color;
    done      = (res_x == res_tx) && (res_y == res_ty);
  end

  assign push      = accept && (is_start || line_active);
  assign push_data = {done, res_color, res_y, res_x};

  // Update line state on each accepted start, and on accepted ticks while active
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        cursor_x    <= in_sx;
        cursor_y    <= in_sy;
        target_x    <= in_ex;
        target_y    <= in_ey;
        delta_x_abs <= dxa_s;
        delta_y_neg <= dyn_s;
        step_x_neg  <= !(in_sx < in_ex);
        step_y_neg  <= !(in_sy < in_ey);
        error_term  <= err_s;
        line_color  <= in_color;
        line_active <= !done;
      end else if (line_active) begin
        cursor_x    <= nx;
        cursor_y    <= ny;
        error_term  <= err_next;
        line_active <= !done;
      end
    end
  end

endmodule

>>> hw/rtl/lrr_queue.sv
// Two-entry queue between the stepper and the rotation stage.
module lrr_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             pop_valid
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue fill level out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != 2'd2) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0) else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with fill level");
`endif

endmodule

>>> hw/rtl/lrr_back.sv
// Back end: holds configuration, rotates pixels and drives the output register.
module lrr_back #(
  parameter int COORD_BITS = lrr_pkg::COORD_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_wr_en,
  input  logic [lrr_pkg::CFG_INDEX_W-1:0]             cfg_index,
  input  logic [lrr_pkg::CFG_DATA_W-1:0]              cfg_wr_data,
  input  logic                                        pop_valid,
  input  logic [2*COORD_BITS+lrr_pkg::COLOR_W:0]      pop_data,
  output logic                                        pop,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // pixel_x, pixel_y, out_color (low bit up)
  output logic [((2*(COORD_BITS+1)+32+7)/8)*8-1:0]    m_tdata,
  output logic                                        m_tlast
);

  localparam int CW = COORD_BITS;
  localparam int OW = CW + 1;
  localparam int MW = CW + lrr_pkg::PANEL_W + 2;
  localparam int TW = ((2*(COORD_BITS+1)+32+7)/8)*8;

  logic [1:0]                  rotation_mode;
  logic [lrr_pkg::PANEL_W-1:0] panel_width, panel_height;

  logic signed [CW-1:0]  q_x, q_y;
  logic [lrr_pkg::COLOR_W-1:0] q_color;
  logic                  q_last;
  logic signed [MW-1:0]  x_m, y_m, w_m, h_m, px_m, py_m;

  assign q_x     = pop_data[0 +: CW];
  assign q_y     = pop_data[CW +: CW];
  assign q_color = pop_data[2*CW +: lrr_pkg::COLOR_W];
  assign q_last  = pop_data[2*CW+lrr_pkg::COLOR_W];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_mode <= lrr_pkg::ROT_0;
      panel_width   <= lrr_pkg::PANEL_WIDTH_RST;
      panel_height  <= lrr_pkg::PANEL_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (lrr_pkg::cfg_index_t'(cfg_index))
        lrr_pkg::CFG_ROTATION:     rotation_mode <= cfg_wr_data[1:0];
        lrr_pkg::CFG_PANEL_WIDTH:  panel_width   <= cfg_wr_data[lrr_pkg::PANEL_W-1:0];
        lrr_pkg::CFG_PANEL_HEIGHT: panel_height  <= cfg_wr_data[lrr_pkg::PANEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Map logical to physical coordinates
  always_comb begin
    x_m = MW'(q_x);
    y_m = MW'(q_y);
    w_m = $signed(MW'(panel_width));
    h_m = $signed(MW'(panel_height));
    unique case (lrr_pkg::rot_mode_t'(rotation_mode))
      lrr_pkg::ROT_90: begin
        px_m = w_m - MW'(1) - y_m;
        py_m = x_m;
      end
      lrr_pkg::ROT_180: begin
        px_m = w_m - MW'(1) - x_m;
        py_m = h_m - MW'(1) - y_m;
      end
      lrr_pkg::ROT_270: begin
        px_m = y_m;
        py_m = h_m - MW'(1) - x_m;
      end
      default: begin
        px_m = x_m;
        py_m = y_m;
      end
    endcase
  end

  assign pop = pop_valid && (!m_tvalid || m_tready);

  // Load the output register whenever it is free or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= TW'({q_color, py_m[OW-1:0], px_m[OW-1:0]});
      m_tlast <= q_last;
    end
  end

endmodule
